// File: src/tped_pkg.sv
// Shared types and constants for the threshold peak event detector.
package tped_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInterval = 3'd1;
  localparam logic [CfgIdxW-1:0] RegClipMargin = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSignMode = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSampleCount = 3'd4;

  localparam logic [1:0] SignBoth = 2'd0;
  localparam logic [1:0] SignPosOnly = 2'd1;
  localparam logic [1:0] SignNegOnly = 2'd2;

  localparam logic [15:0] ThresholdRst = 16'd1000;
  localparam logic [15:0] IntervalRst = 16'd10;
  localparam logic [15:0] ClipMarginRst = 16'd0;
  localparam logic [1:0] SignModeRst = SignBoth;
  localparam logic [31:0] SampleCountRst = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [TimeW-1:0] det_time;
    logic             last;
  } result_t;

endpackage

// File: src/threshold_peak_event_detector_top.sv
// Top level of the threshold peak event detector with refractory peak picking.
// Each result is written into the registered result queue and presented from its head.
// Throughput: one sample per cycle while the four-entry result queue has room for two results.
// A sample causes at most two results; the output side drains one result per cycle while out_stall_i is low.
// Reset (rst_ni low, asynchronous) restores register defaults, clears position and pending peak,
// and empties the result queue; no clearing pass follows.
module threshold_peak_event_detector_top #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [tped_pkg::TimeW-1:0]           detection_time_o,
  output logic                                 last_in_run_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tped_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [tped_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned MagW = SAMPLE_BITS + 1;
  localparam int unsigned CmpW = (MagW > 16) ? MagW : 16;
  localparam int unsigned TW = tped_pkg::TimeW;

  logic [15:0] threshold_q;
  logic [15:0] interval_q;
  logic [15:0] clip_margin_q;
  logic [1:0]  sign_mode_q;
  logic [31:0] sample_count_q;

  logic [TW-1:0]   position_q, position_d;
  logic [TW-1:0]   peak_index_q, peak_index_d;
  logic [MagW-1:0] peak_mag_q, peak_mag_d;

  tped_pkg::result_t queue_q [tped_pkg::QDepth];
  logic [tped_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [tped_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [tped_pkg::QCntW-1:0] cnt_q, cnt_d;

  logic            in_accept, pop, cfg_we;
  logic            neg;
  logic [MagW-1:0] mag_raw, mag;
  logic [TW:0]     pos_ext, count_ext, clip_ext;
  logic [CmpW-1:0] thr_cmp, mag_cmp;
  logic            in_window, expire, take, end_rec, flush;
  logic [MagW-1:0] mag_after, mag_mid;
  logic [TW-1:0]   idx_mid;
  logic [1:0]      push_n;
  tped_pkg::result_t res_a, res_b;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign in_stall_o = (cnt_q > tped_pkg::QCntW'(tped_pkg::QDepth - 2));
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop = out_valid_o && !out_stall_i;
  assign detection_time_o = queue_q[rd_ptr_q].det_time;
  assign last_in_run_o = queue_q[rd_ptr_q].last;

  always_comb begin
    neg = sample_i[SAMPLE_BITS-1];
    mag_raw = neg ? (MagW'(0) - {1'b1, sample_i}) : {1'b0, sample_i};
    unique case (sign_mode_q)
      tped_pkg::SignPosOnly: mag = neg ? '0 : mag_raw;
      tped_pkg::SignNegOnly: mag = neg ? mag_raw : '0;
      default:               mag = mag_raw;
    endcase

    pos_ext = {1'b0, position_q};
    clip_ext = {(TW + 1 - 16)'(0), clip_margin_q};
    count_ext = (sample_count_q == '0) ? (TW + 1)'(1) : {1'b0, sample_count_q};
    thr_cmp = (threshold_q == '0) ? CmpW'(1) : CmpW'(threshold_q);
    mag_cmp = CmpW'(mag);

    in_window = (pos_ext >= clip_ext) && ((pos_ext + clip_ext) < count_ext);
    expire = in_window && (peak_mag_q != '0) &&
             ((pos_ext - {1'b0, peak_index_q}) > {(TW + 1 - 16)'(0), interval_q});
    mag_after = expire ? '0 : peak_mag_q;
    take = in_window && (mag_cmp >= thr_cmp) && ((mag_after == '0) || (mag > mag_after));
    mag_mid = take ? mag : mag_after;
    idx_mid = take ? position_q : peak_index_q;
    end_rec = ((pos_ext + (TW + 1)'(1)) >= count_ext);
    flush = end_rec && (mag_mid != '0);

    res_a.det_time = expire ? (peak_index_q + TW'(1)) : (idx_mid + TW'(1));
    res_a.last = !(expire && flush);
    res_b.det_time = idx_mid + TW'(1);
    res_b.last = 1'b1;
    push_n = in_accept ? (2'(expire) + 2'(flush)) : 2'd0;

    position_d = position_q;
    peak_index_d = peak_index_q;
    peak_mag_d = peak_mag_q;
    if (in_accept) begin
      if (end_rec) begin
        position_d = '0;
        peak_index_d = '0;
        peak_mag_d = '0;
      end else begin
        position_d = position_q + TW'(1);
        peak_index_d = idx_mid;
        peak_mag_d = mag_mid;
      end
    end

    wr_ptr_d = wr_ptr_q + tped_pkg::QPtrW'(push_n);
    rd_ptr_d = rd_ptr_q + tped_pkg::QPtrW'(pop);
    cnt_d = cnt_q + tped_pkg::QCntW'(push_n) - tped_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= tped_pkg::ThresholdRst;
      interval_q <= tped_pkg::IntervalRst;
      clip_margin_q <= tped_pkg::ClipMarginRst;
      sign_mode_q <= tped_pkg::SignModeRst;
      sample_count_q <= tped_pkg::SampleCountRst;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        tped_pkg::RegThreshold:   threshold_q <= cfg_data_i[15:0];
        tped_pkg::RegInterval:    interval_q <= cfg_data_i[15:0];
        tped_pkg::RegClipMargin:  clip_margin_q <= cfg_data_i[15:0];
        tped_pkg::RegSignMode:    sign_mode_q <= cfg_data_i[1:0];
        tped_pkg::RegSampleCount: sample_count_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      peak_index_q <= '0;
      peak_mag_q <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      position_q <= position_d;
      peak_index_q <= peak_index_d;
      peak_mag_q <= peak_mag_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= res_a;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + tped_pkg::QPtrW'(1)] <= res_b;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tped_pkg::QCntW'(tped_pkg::QDepth))
    else $error("result queue overflow");

  a_peak_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (peak_mag_q != '0) |-> (peak_index_q <= position_q))
    else $error("pending peak lies ahead of position");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_n == 2'd0)) |=> (cnt_q == $past(cnt_q) - tped_pkg::QCntW'(1)))
    else $error("queue count did not drop on pop");

  a_end_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && end_rec) |=> ((position_q == '0) && (peak_mag_q == '0)))
    else $error("record end did not restart state");

endmodule
